// ===== design/esckd_pkg.sv =====
// Package: key codes, byte constants, item types and sequence decode functions.
`default_nettype none
package esckd_pkg;

	// Key kinds
	localparam logic [3:0] KIND_PLAIN     = 4'd0;
	localparam logic [3:0] KIND_BACKSPACE = 4'd1;
	localparam logic [3:0] KIND_ESC       = 4'd2;
	localparam logic [3:0] KIND_HOME      = 4'd3;
	localparam logic [3:0] KIND_DELETE    = 4'd4;
	localparam logic [3:0] KIND_END       = 4'd5;
	localparam logic [3:0] KIND_PGUP      = 4'd6;
	localparam logic [3:0] KIND_PGDN      = 4'd7;
	localparam logic [3:0] KIND_UP        = 4'd8;
	localparam logic [3:0] KIND_DOWN      = 4'd9;
	localparam logic [3:0] KIND_RIGHT     = 4'd10;
	localparam logic [3:0] KIND_LEFT      = 4'd11;

	// Byte values
	localparam logic [7:0] BYTE_ESC     = 8'h1B;
	localparam logic [7:0] BYTE_DEL     = 8'h7F;
	localparam logic [7:0] BYTE_BS      = 8'h08;
	localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
	localparam logic [7:0] CHAR_O       = 8'h4F;
	localparam logic [7:0] CHAR_TILDE   = 8'h7E;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_ONE     = 8'h31;
	localparam logic [7:0] CHAR_THREE   = 8'h33;
	localparam logic [7:0] CHAR_FOUR    = 8'h34;
	localparam logic [7:0] CHAR_FIVE    = 8'h35;
	localparam logic [7:0] CHAR_SIX     = 8'h36;
	localparam logic [7:0] CHAR_SEVEN   = 8'h37;
	localparam logic [7:0] CHAR_EIGHT   = 8'h38;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_B       = 8'h42;
	localparam logic [7:0] CHAR_C       = 8'h43;
	localparam logic [7:0] CHAR_D       = 8'h44;
	localparam logic [7:0] CHAR_F       = 8'h46;
	localparam logic [7:0] CHAR_H       = 8'h48;

	// One received item
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timeout;
	} item_t;

	// One decoded key, with a flag that says whether the item yields one
	typedef struct packed {
		logic       hit;
		logic [3:0] key_kind;
		logic [7:0] key_byte;
	} result_t;

	// Key for ESC [ digit ~
	function automatic logic [3:0] tilde_kind(input logic [7:0] digit);
		logic [3:0] kind;
		begin
			unique case (digit)
				CHAR_ONE, CHAR_SEVEN:  kind = KIND_HOME;
				CHAR_THREE:            kind = KIND_DELETE;
				CHAR_FOUR, CHAR_EIGHT: kind = KIND_END;
				CHAR_FIVE:             kind = KIND_PGUP;
				CHAR_SIX:              kind = KIND_PGDN;
				default:               kind = KIND_ESC;
			endcase
			return kind;
		end
	endfunction

	// Key for a two-byte sequence after ESC
	function automatic logic [3:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [3:0] kind;
		begin
			kind = KIND_ESC;
			if (a == CHAR_LBRACK) begin
				unique case (b)
					CHAR_A:  kind = KIND_UP;
					CHAR_B:  kind = KIND_DOWN;
					CHAR_C:  kind = KIND_RIGHT;
					CHAR_D:  kind = KIND_LEFT;
					CHAR_H:  kind = KIND_HOME;
					CHAR_F:  kind = KIND_END;
					default: kind = KIND_ESC;
				endcase
			end else if (a == CHAR_O) begin
				if (b == CHAR_H) begin
					kind = KIND_HOME;
				end else if (b == CHAR_F) begin
					kind = KIND_END;
				end
			end
			return kind;
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/esckd_byte_if.sv =====
// Interface: input byte channel (valid/ready with received byte and timeout flag).
`default_nettype none
interface esckd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       timeout;

	modport source(output valid, output rx_byte, output timeout, input ready);
	modport sink(input valid, input rx_byte, input timeout, output ready);
endinterface
`default_nettype wire

// ===== design/esckd_key_if.sv =====
// Interface: decoded key channel (valid/ready with key kind and raw byte).
`default_nettype none
interface esckd_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_kind;
	logic [7:0] key_byte;

	modport source(output valid, output key_kind, output key_byte, input ready);
	modport sink(input valid, input key_kind, input key_byte, output ready);
endinterface
`default_nettype wire

// ===== design/escape_sequence_key_decoder_top.sv =====
// Top level: terminal escape sequence key decoder.
//
//   channel | dir | payload                      | handshake
//   rx      | in  | rx_byte[7:0], timeout        | valid/ready
//   key     | out | key_kind[3:0], key_byte[7:0] | valid/ready
//
// One item per cycle while the key output is not stalled; an rx transfer passes through
// the input register, decode and the output register before key valid.
// Reset clears the parse phase and both stage valid flags; sequence bytes are not reset.
// An item that yields no key leaves the input register even while the output is stalled;
// an item that yields a key waits in the input register until the output register frees.
`default_nettype none
module escape_sequence_key_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	esckd_byte_if.sink  rx,
	esckd_key_if.source key
);
	import esckd_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	result_t result;
	logic    can_load;
	logic    advance;

	// Move the item on when it needs no output slot or a slot is free
	assign advance = valid_s1 && (!result.hit || can_load);

	esckd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	esckd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.result   (result)
	);

	esckd_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && result.hit),
		.result   (result),
		.can_load (can_load),
		.key      (key)
	);
endmodule
`default_nettype wire

// ===== design/esckd_in_stage.sv =====
// Input register stage: holds one received item until the parser takes it.
`default_nettype none
module esckd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	esckd_byte_if.sink      rx,
	input  logic            advance,
	output logic            valid_s1,
	output esckd_pkg::item_t item_s1
);
	import esckd_pkg::*;

	logic  vld_s1;
	item_t itm_s1;

	// Accept a new transfer when the stage is empty or drains this cycle
	assign rx.ready = !vld_s1 || advance;

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	// Capture payload on transfer
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			itm_s1.rx_byte <= rx.rx_byte;
			itm_s1.timeout <= rx.timeout;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = itm_s1;
endmodule
`default_nettype wire

// ===== design/esckd_parser.sv =====
// Sequence parser: phase and sequence byte registers plus per-item decode.
`default_nettype none
module esckd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  esckd_pkg::item_t   item_s1,
	input  logic               advance,
	output esckd_pkg::result_t result
);
	import esckd_pkg::*;

	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_GOT_ESC   = 2'd1;
	localparam logic [1:0] PH_GOT_FIRST = 2'd2;
	localparam logic [1:0] PH_GOT_DIGIT = 2'd3;

	logic [1:0] phase_q;
	logic [1:0] phase_nxt;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       load_first;
	logic       load_second;
	logic       is_digit;
	logic [7:0] b;
	result_t    res;

	assign b        = item_s1.rx_byte;
	assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

	// Decode the item against the current phase
	always_comb begin
		phase_nxt    = phase_q;
		load_first   = 1'b0;
		load_second  = 1'b0;
		res.hit      = 1'b0;
		res.key_kind = KIND_PLAIN;
		res.key_byte = 8'd0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item_s1.timeout) begin
					phase_nxt = PH_IDLE;
				end else if (b == BYTE_DEL || b == BYTE_BS) begin
					res.hit      = 1'b1;
					res.key_kind = KIND_BACKSPACE;
				end else if (b == BYTE_ESC) begin
					phase_nxt = PH_GOT_ESC;
				end else begin
					res.hit      = 1'b1;
					res.key_kind = KIND_PLAIN;
					res.key_byte = b;
				end
			end
			PH_GOT_ESC: begin
				if (item_s1.timeout) begin
					phase_nxt    = PH_IDLE;
					res.hit      = 1'b1;
					res.key_kind = KIND_ESC;
				end else begin
					load_first = 1'b1;
					phase_nxt  = PH_GOT_FIRST;
				end
			end
			PH_GOT_FIRST: begin
				if (item_s1.timeout) begin
					phase_nxt    = PH_IDLE;
					res.hit      = 1'b1;
					res.key_kind = KIND_ESC;
				end else begin
					load_second = 1'b1;
					if (first_q == CHAR_LBRACK && is_digit) begin
						phase_nxt = PH_GOT_DIGIT;
					end else begin
						phase_nxt    = PH_IDLE;
						res.hit      = 1'b1;
						res.key_kind = pair_kind(first_q, b);
					end
				end
			end
			PH_GOT_DIGIT: begin
				phase_nxt    = PH_IDLE;
				res.hit      = 1'b1;
				if (!item_s1.timeout && b == CHAR_TILDE) begin
					res.key_kind = tilde_kind(second_q);
				end else begin
					res.key_kind = KIND_ESC;
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase
		res.hit = res.hit && valid_s1;
	end

	// Advance phase when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (advance) begin
			phase_q <= phase_nxt;
		end
	end

	// Hold the sequence bytes
	always_ff @(posedge clk) begin
		if (advance && load_first) begin
			first_q <= b;
		end
		if (advance && load_second) begin
			second_q <= b;
		end
	end

	assign result = res;
endmodule
`default_nettype wire

// ===== design/esckd_out_stage.sv =====
// Output register stage: holds one decoded key until the consumer takes it.
`default_nettype none
module esckd_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  esckd_pkg::result_t result,
	output logic               can_load,
	esckd_key_if.source        key
);
	import esckd_pkg::*;

	logic       valid_q;
	logic [3:0] kind_q;
	logic [7:0] byte_q;

	// Room when empty or when the held key transfers this cycle
	assign can_load = !valid_q || key.ready;

	// Hold valid until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// Capture decoded key
	always_ff @(posedge clk) begin
		if (load && can_load) begin
			kind_q <= result.key_kind;
			byte_q <= result.key_byte;
		end
	end

	assign key.valid    = valid_q;
	assign key.key_kind = kind_q;
	assign key.key_byte = byte_q;
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench: random and directed byte streams through the escape key decoder, checked per key.
module testbench;
	import esckd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 12;
	localparam int RANDOM_ITEMS   = 1700;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GOT_ESC,
		ST_GOT_LEAD,
		ST_GOT_DIGIT
	} parse_state_e;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] raw;
	} key_t;

	logic clk;
	logic arst_n;

	esckd_byte_if rx();
	esckd_key_if  key();

	escape_sequence_key_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.key(key)
	);

	// Decoder state mirrored on the testbench side
	parse_state_e parse_state;
	logic [7:0]   seq_lead;
	logic [7:0]   seq_digit;

	item_t pending_items[$];
	key_t  expected_keys[$];
	int    stim_count;
	int    mismatches;
	int    idle_cycles;
	int    burst_left;
	int    gap_left;
	int    stall_cycle;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the key, if any, that one accepted item yields, and advance the parse state
	function automatic bit decode_key(input logic [7:0] b, input logic to, output key_t k);
		k.kind = KIND_ESC;
		k.raw  = 8'h00;
		if (parse_state == ST_IDLE) begin
			if (to) begin
				return 1'b0;
			end
			if (b == BYTE_DEL || b == BYTE_BS) begin
				k.kind = KIND_BACKSPACE;
				return 1'b1;
			end
			if (b == BYTE_ESC) begin
				parse_state = ST_GOT_ESC;
				return 1'b0;
			end
			k.kind = KIND_PLAIN;
			k.raw  = b;
			return 1'b1;
		end
		// a timeout inside a sequence drops it and reports ESC
		if (to) begin
			parse_state = ST_IDLE;
			return 1'b1;
		end
		case (parse_state)
			ST_GOT_ESC: begin
				seq_lead    = b;
				parse_state = ST_GOT_LEAD;
				return 1'b0;
			end
			ST_GOT_LEAD: begin
				seq_digit = b;
				if (seq_lead == CHAR_LBRACK && b >= CHAR_ZERO && b <= CHAR_NINE) begin
					parse_state = ST_GOT_DIGIT;
					return 1'b0;
				end
				parse_state = ST_IDLE;
				if (seq_lead == CHAR_LBRACK) begin
					case (b)
						CHAR_A: k.kind = KIND_UP;
						CHAR_B: k.kind = KIND_DOWN;
						CHAR_C: k.kind = KIND_RIGHT;
						CHAR_D: k.kind = KIND_LEFT;
						CHAR_H: k.kind = KIND_HOME;
						CHAR_F: k.kind = KIND_END;
						default: k.kind = KIND_ESC;
					endcase
				end else if (seq_lead == CHAR_O) begin
					if (b == CHAR_H) k.kind = KIND_HOME;
					else if (b == CHAR_F) k.kind = KIND_END;
				end
				return 1'b1;
			end
			default: begin
				parse_state = ST_IDLE;
				if (b == CHAR_TILDE) begin
					case (seq_digit)
						CHAR_ONE, CHAR_SEVEN:  k.kind = KIND_HOME;
						CHAR_THREE:            k.kind = KIND_DELETE;
						CHAR_FOUR, CHAR_EIGHT: k.kind = KIND_END;
						CHAR_FIVE:             k.kind = KIND_PGUP;
						CHAR_SIX:              k.kind = KIND_PGDN;
						default:               k.kind = KIND_ESC;
					endcase
				end
				return 1'b1;
			end
		endcase
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		item_t it;
		it.rx_byte = b;
		it.timeout = 1'b0;
		pending_items.push_back(it);
		stim_count++;
	endtask

	// Timeout items carry a random byte that the decoder must ignore
	task automatic queue_timeout(input bit counts);
		item_t it;
		it.rx_byte = 8'($urandom);
		it.timeout = 1'b1;
		pending_items.push_back(it);
		if (counts) stim_count++;
	endtask

	// Drive the byte channel in bursts with random gaps
	always @(posedge clk) begin
		item_t nxt;
		key_t  k;
		if (!arst_n) begin
			rx.valid   <= 1'b0;
			rx.rx_byte <= 8'h00;
			rx.timeout <= 1'b0;
			burst_left = $urandom_range(1, 40);
			gap_left   = 0;
		end else begin
			if (rx.valid && rx.ready) begin
				if (decode_key(rx.rx_byte, rx.timeout, k)) expected_keys.push_back(k);
			end
			if (rx.valid && !rx.ready) begin
				// hold the current transfer
			end else if (gap_left != 0) begin
				gap_left--;
				rx.valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				rx.valid   <= 1'b1;
				rx.rx_byte <= nxt.rx_byte;
				rx.timeout <= nxt.timeout;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// Stall the key channel, switching pattern as stall_cycle[9:8] changes
	always @(posedge clk) begin
		if (!arst_n) begin
			key.ready   <= 1'b0;
			stall_cycle <= 0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			case (stall_cycle[9:8])
				2'd0: key.ready <= 1'b1;
				2'd1: key.ready <= ($urandom_range(0, 3) != 0);
				2'd2: key.ready <= (stall_cycle[2:0] != 3'd5) && (stall_cycle[2:0] != 3'd6);
				default: key.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Check each key transfer against the oldest expectation
	always @(posedge clk) begin
		key_t want;
		if (arst_n && key.valid && key.ready) begin
			if (expected_keys.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected key: kind %0d byte %02h", key.key_kind, key.key_byte);
			end else begin
				want = expected_keys.pop_front();
				if (key.key_kind !== want.kind || key.key_byte !== want.raw) begin
					mismatches++;
					if (mismatches <= 10)
						$display("key mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
							want.kind, want.raw, key.key_kind, key.key_byte);
				end
			end
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((rx.valid && rx.ready) || (key.valid && key.ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] letters [6];
		int         pick;
		int         n;
		clk         = 1'b0;
		arst_n      = 1'b0;
		rx.valid    = 1'b0;
		rx.rx_byte  = 8'h00;
		rx.timeout  = 1'b0;
		key.ready   = 1'b0;
		parse_state = ST_IDLE;
		seq_lead    = 8'h00;
		seq_digit   = 8'h00;
		stim_count  = 0;
		mismatches  = 0;
		letters = '{CHAR_A, CHAR_B, CHAR_C, CHAR_D, CHAR_H, CHAR_F};

		// Directed: byte extremes, backspace codes, idle timeout
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(BYTE_DEL);
		queue_byte(BYTE_BS);
		queue_timeout(1'b0);
		// recognized pair and tilde forms, an unknown digit, a bad terminator
		queue_byte(BYTE_ESC); queue_byte(CHAR_LBRACK); queue_byte(CHAR_A);
		queue_byte(BYTE_ESC); queue_byte(CHAR_O); queue_byte(CHAR_H);
		queue_byte(BYTE_ESC); queue_byte(CHAR_LBRACK); queue_byte(CHAR_THREE);
		queue_byte(CHAR_TILDE);
		queue_byte(BYTE_ESC); queue_byte(CHAR_LBRACK); queue_byte(CHAR_NINE);
		queue_byte(CHAR_TILDE);
		queue_byte(BYTE_ESC); queue_byte(CHAR_LBRACK); queue_byte(CHAR_FIVE);
		queue_byte(8'h78);
		// timeout inside a sequence, ESC as a sequence byte
		queue_byte(BYTE_ESC); queue_timeout(1'b1);
		queue_byte(BYTE_ESC); queue_byte(BYTE_ESC); queue_byte(8'h5A);

		// Random: mostly well-formed sequences with random content, some noise
		n = stim_count + RANDOM_ITEMS;
		while (stim_count < n) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1: queue_byte(8'($urandom));
				2: queue_byte($urandom_range(0, 1) ? BYTE_DEL : BYTE_BS);
				3: queue_timeout(1'b1);
				4: begin
					queue_byte(BYTE_ESC);
					queue_byte(CHAR_LBRACK);
					queue_byte(($urandom_range(0, 4) != 0) ? letters[$urandom_range(0, 5)]
						: 8'($urandom));
				end
				5: begin
					queue_byte(BYTE_ESC);
					queue_byte(CHAR_O);
					case ($urandom_range(0, 2))
						0: queue_byte(CHAR_H);
						1: queue_byte(CHAR_F);
						default: queue_byte(8'($urandom));
					endcase
				end
				6, 7: begin
					queue_byte(BYTE_ESC);
					queue_byte(CHAR_LBRACK);
					queue_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
					queue_byte(($urandom_range(0, 4) != 0) ? CHAR_TILDE : 8'($urandom));
				end
				8: begin
					queue_byte(BYTE_ESC);
					queue_byte(8'($urandom));
					queue_byte(8'($urandom));
				end
				default: begin
					// broken sequence cut off by a timeout
					queue_byte(BYTE_ESC);
					if ($urandom_range(0, 1)) begin
						queue_byte(CHAR_LBRACK);
						if ($urandom_range(0, 1))
							queue_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
					end
					queue_timeout(1'b1);
				end
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every item sent and every key seen, then a short tail
		@(negedge clk);
		while (pending_items.size() != 0 || rx.valid || expected_keys.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_keys.size() != 0) begin
			mismatches++;
			$display("%0d expected keys never arrived", expected_keys.size());
		end
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/esckd_pkg.sv
design/esckd_byte_if.sv
design/esckd_key_if.sv
design/esckd_in_stage.sv
design/esckd_parser.sv
design/esckd_out_stage.sv
design/escape_sequence_key_decoder_top.sv
verif/testbench.sv
